[rtl/pldd_pkg.sv]
// Shared types, register codes and arithmetic constants of the line-follow PID drive.
package pldd_pkg;

  localparam int SENSOR_COUNT = 5;
  localparam int SAMPLE_W     = 10;
  localparam int IN_W         = SENSOR_COUNT * SAMPLE_W;
  localparam int IN_BYTES_W   = ((IN_W + 7) / 8) * 8;
  localparam int SCALED_W     = 7;
  localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
  localparam int DRIVE_W      = 8;
  localparam int ERR_W        = 8;
  localparam int INTEGRAL_W   = 24;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 20;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 29;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Reciprocal constants: floor(x / d) = (x * M) >> S over the ranges used.
  localparam logic [23:0] SCALE_MUL    = 24'd13120100;  // v * 100 / 1023
  localparam int          SCALE_SHIFT  = 27;
  localparam logic [14:0] DIV100_MUL   = 15'd20972;     // x / 100
  localparam int          DIV100_SHIFT = 21;
  localparam logic [17:0] MAP_MUL      = 18'd255760;    // t * 200 / 410
  localparam int          MAP_SHIFT    = 19;
  localparam logic [28:0] RECIP_1000   = 29'd274877907; // x / 1000, x below 2**28
  localparam int          RECIP_SHIFT  = 38;

  // Error offset of the remapping and magnitude used when the integral term saturates.
  localparam logic [8:0]  MAP_OFFSET = 9'd205;
  localparam logic [7:0]  ERR_CENTRE = 8'd100;
  localparam logic [18:0] I_SAT_MAG  = 19'd262144;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_SPEED   = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_GAIN_I       = 3'd3,
    REG_BORDER_LEVEL = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic signed [7:0] base_speed;
    logic [15:0]       gain_p;
    logic [19:0]       gain_d;
    logic [15:0]       gain_i;
    logic [6:0]        border_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    base_speed:   8'sd40,
    gain_p:       16'd8000,
    gain_d:       20'd64000,
    gain_i:       16'd3,
    border_level: 7'd50
  };

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_left;
    logic signed [DRIVE_W-1:0] drive_right;
    logic                      line_present;
  } result_t;

endpackage

[rtl/pid_line_follow_drive.sv]
// An accepted item steps through the sequencer states from scale to done; its result is
// then offered on the master side from the output register. The one shared multiplier
// computes thirteen products in turn; a new item is taken only when the sequencer is idle.
// A new item may be accepted while the previous result still waits in the output register.
// Reset (synchronous, active high) idles the sequencer, drops the output valid, clears the
// error history and integral, and restores every configuration register to its default.
module pid_line_follow_drive (
  input  logic                              clk,
  input  logic                              rst,
  // Sensor items: tdata holds from bit 0 up sensor_far_left, sensor_near_left,
  // sensor_center, sensor_near_right, sensor_far_right (10 bits each), 6 zero bits.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pldd_pkg::IN_BYTES_W-1:0]   s_axis_tdata,
  // Drive items: tdata holds drive_left [7:0] and drive_right [15:8];
  // tuser holds line_present.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*pldd_pkg::DRIVE_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tuser,
  // Register writes: index selects the register, data is taken from bit 0 up.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pldd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pldd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pldd_pkg::cfg_t    cfg;
  pldd_pkg::result_t res, out_q;
  logic                             start, idle, res_valid, res_ready, out_valid;
  logic [pldd_pkg::MUL_A_W-1:0]     mul_a;
  logic [pldd_pkg::MUL_B_W-1:0]     mul_b;
  logic [pldd_pkg::PROD_W-1:0]      mul_p;

  // The register file accepts a write in every cycle; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pldd_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (pldd_pkg::cfg_index_t'(cfg_index))
        pldd_pkg::REG_BASE_SPEED:   cfg.base_speed   <= signed'(cfg_data[7:0]);
        pldd_pkg::REG_GAIN_P:       cfg.gain_p       <= cfg_data[15:0];
        pldd_pkg::REG_GAIN_D:       cfg.gain_d       <= cfg_data[19:0];
        pldd_pkg::REG_GAIN_I:       cfg.gain_i       <= cfg_data[15:0];
        pldd_pkg::REG_BORDER_LEVEL: cfg.border_level <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer takes an item only when it is idle; the output register
  // decouples it from the consumer.
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign res_ready     = !out_valid || m_axis_tready;

  pldd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_data   (s_axis_tdata[pldd_pkg::IN_W-1:0]),
    .cfg       (cfg),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_p     (mul_p)
  );

  pldd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Output register: loaded when the sequencer finishes and the slot is free
  // or being emptied in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_q.drive_right, out_q.drive_left};
  assign m_axis_tuser  = out_q.line_present;

endmodule

[rtl/pldd_mul.sv]
// Shared unsigned multiplier with a registered product.
module pldd_mul (
  input  logic                          clk,
  input  logic [pldd_pkg::MUL_A_W-1:0]  a,
  input  logic [pldd_pkg::MUL_B_W-1:0]  b,
  output logic [pldd_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= pldd_pkg::PROD_W'(a) * pldd_pkg::PROD_W'(b);
  end

endmodule

[rtl/pldd_seq.sv]
// Sequencer and datapath registers that step one item through the shared multiplier.
module pldd_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [pldd_pkg::IN_W-1:0]           in_data,
  input  pldd_pkg::cfg_t                      cfg,
  output logic                                idle,
  output logic                                res_valid,
  input  logic                                res_ready,
  output pldd_pkg::result_t                   res,
  output logic [pldd_pkg::MUL_A_W-1:0]        mul_a,
  output logic [pldd_pkg::MUL_B_W-1:0]        mul_b,
  input  logic [pldd_pkg::PROD_W-1:0]         mul_p
);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_SCALE   = 12'b0000_0000_0010,
    ST_ERR_DIV = 12'b0000_0000_0100,
    ST_ERR_MAP = 12'b0000_0000_1000,
    ST_P_MUL   = 12'b0000_0001_0000,
    ST_P_DIV   = 12'b0000_0010_0000,
    ST_D_MUL   = 12'b0000_0100_0000,
    ST_D_DIV   = 12'b0000_1000_0000,
    ST_I_MUL   = 12'b0001_0000_0000,
    ST_I_DIV   = 12'b0010_0000_0000,
    ST_SUM     = 12'b0100_0000_0000,
    ST_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic [pldd_pkg::CNT_W-1:0]        cnt;
  logic [pldd_pkg::SAMPLE_W-1:0]     samp [pldd_pkg::SENSOR_COUNT];
  logic [pldd_pkg::SCALED_W-1:0]     scaled [pldd_pkg::SENSOR_COUNT];
  logic                              all_below, all_above, neg, i_sat;
  logic signed [pldd_pkg::ERR_W-1:0] err, prev_err;
  logic signed [13:0]                term_p;
  logic signed [18:0]                term_d;
  logic signed [pldd_pkg::INTEGRAL_W-1:0] integral;

  logic [pldd_pkg::SCALED_W-1:0]     scaled_now;
  logic                              scan_done;
  logic signed [7:0]                 d04, d13;
  logic signed [15:0]                n_sum;
  logic [14:0]                       n_mag;
  logic [7:0]                        q_div100, m_map;
  logic [8:0]                        map_in;
  logic signed [pldd_pkg::ERR_W-1:0] err_now;
  logic [6:0]                        err_mag;
  logic signed [8:0]                 diff;
  logic [7:0]                        diff_mag;
  logic [pldd_pkg::INTEGRAL_W-1:0]   int_mag;
  logic [12:0]                       q_p;
  logic [17:0]                       q_d;
  logic [18:0]                       q_i;
  logic signed [19:0]                term_i;
  logic signed [21:0]                steer;
  logic signed [22:0]                left_full, right_full;
  logic signed [pldd_pkg::INTEGRAL_W:0] int_sum;
  logic signed [pldd_pkg::INTEGRAL_W-1:0] int_sat;
  logic                              present;

  function automatic logic signed [pldd_pkg::DRIVE_W-1:0] clamp_drive(
    input logic signed [22:0] v
  );
    logic signed [pldd_pkg::DRIVE_W-1:0] r;
    if (v > 23'sd100) begin
      r = 8'sd100;
    end else if (v < -23'sd100) begin
      r = -8'sd100;
    end else begin
      r = pldd_pkg::DRIVE_W'(v);
    end
    return r;
  endfunction

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign scan_done = (cnt == pldd_pkg::CNT_W'(pldd_pkg::SENSOR_COUNT));

  // Arithmetic around the multiplier, narrow and local to each step.
  always_comb begin
    scaled_now = mul_p[pldd_pkg::SCALE_SHIFT +: pldd_pkg::SCALED_W];
    d04   = signed'({1'b0, scaled[0]}) - signed'({1'b0, scaled[4]});
    d13   = signed'({1'b0, scaled[1]}) - signed'({1'b0, scaled[3]});
    // 5 * d04 + 200 * d13 by shifts and adds.
    n_sum = (16'(d04) <<< 2) + 16'(d04)
          + (16'(d13) <<< 7) + (16'(d13) <<< 6) + (16'(d13) <<< 3);
    n_mag = n_sum[15] ? 15'(-n_sum) : 15'(n_sum);

    q_div100 = mul_p[pldd_pkg::DIV100_SHIFT +: 8];
    map_in   = neg ? (pldd_pkg::MAP_OFFSET - 9'(q_div100))
                   : (pldd_pkg::MAP_OFFSET + 9'(q_div100));

    m_map   = mul_p[pldd_pkg::MAP_SHIFT +: 8];
    err_now = signed'(m_map - pldd_pkg::ERR_CENTRE);
    err_mag = err_now[pldd_pkg::ERR_W-1] ? 7'(-err_now) : 7'(err_now);

    diff     = 9'(err) - 9'(prev_err);
    diff_mag = diff[8] ? 8'(-diff) : 8'(diff);
    int_mag  = integral[pldd_pkg::INTEGRAL_W-1] ? pldd_pkg::INTEGRAL_W'(-integral)
                                                : pldd_pkg::INTEGRAL_W'(integral);

    q_p = mul_p[pldd_pkg::RECIP_SHIFT +: 13];
    q_d = mul_p[pldd_pkg::RECIP_SHIFT +: 18];
    q_i = i_sat ? pldd_pkg::I_SAT_MAG : mul_p[pldd_pkg::RECIP_SHIFT +: 19];
    term_i = neg ? -signed'({1'b0, q_i}) : signed'({1'b0, q_i});

    steer      = 22'(term_p) + 22'(term_d) + 22'(term_i);
    left_full  = 23'(cfg.base_speed) - 23'(steer);
    right_full = 23'(cfg.base_speed) + 23'(steer);

    int_sum = (pldd_pkg::INTEGRAL_W + 1)'(integral) + (pldd_pkg::INTEGRAL_W + 1)'(err);
    if (int_sum > signed'({2'b00, {(pldd_pkg::INTEGRAL_W - 1){1'b1}}})) begin
      int_sat = {1'b0, {(pldd_pkg::INTEGRAL_W - 1){1'b1}}};
    end else if (int_sum < signed'({2'b11, {(pldd_pkg::INTEGRAL_W - 1){1'b0}}})) begin
      int_sat = {1'b1, {(pldd_pkg::INTEGRAL_W - 1){1'b0}}};
    end else begin
      int_sat = pldd_pkg::INTEGRAL_W'(int_sum);
    end

    present = !all_below && !all_above;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SCALE: begin
        if (!scan_done) begin
          mul_a = pldd_pkg::MUL_A_W'(samp[cnt]);
          mul_b = pldd_pkg::MUL_B_W'(pldd_pkg::SCALE_MUL);
        end
      end
      ST_ERR_DIV: begin
        mul_a = pldd_pkg::MUL_A_W'(n_mag);
        mul_b = pldd_pkg::MUL_B_W'(pldd_pkg::DIV100_MUL);
      end
      ST_ERR_MAP: begin
        mul_a = pldd_pkg::MUL_A_W'(map_in);
        mul_b = pldd_pkg::MUL_B_W'(pldd_pkg::MAP_MUL);
      end
      ST_P_MUL: begin
        mul_a = pldd_pkg::MUL_A_W'(err_mag);
        mul_b = pldd_pkg::MUL_B_W'(cfg.gain_p);
      end
      ST_D_MUL: begin
        mul_a = pldd_pkg::MUL_A_W'(diff_mag);
        mul_b = pldd_pkg::MUL_B_W'(cfg.gain_d);
      end
      ST_I_MUL: begin
        mul_a = pldd_pkg::MUL_A_W'(int_mag);
        mul_b = pldd_pkg::MUL_B_W'(cfg.gain_i);
      end
      ST_P_DIV, ST_D_DIV, ST_I_DIV: begin
        mul_a = mul_p[pldd_pkg::MUL_A_W-1:0];
        mul_b = pldd_pkg::RECIP_1000;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (start) state_next = ST_SCALE;
      ST_SCALE:   if (scan_done) state_next = ST_ERR_DIV;
      ST_ERR_DIV: state_next = ST_ERR_MAP;
      ST_ERR_MAP: state_next = ST_P_MUL;
      ST_P_MUL:   state_next = ST_P_DIV;
      ST_P_DIV:   state_next = ST_D_MUL;
      ST_D_MUL:   state_next = ST_D_DIV;
      ST_D_DIV:   state_next = ST_I_MUL;
      ST_I_MUL:   state_next = ST_I_DIV;
      ST_I_DIV:   state_next = ST_SUM;
      ST_SUM:     state_next = ST_DONE;
      ST_DONE:    if (res_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (state == ST_SCALE) begin
        cnt <= cnt + pldd_pkg::CNT_W'(1);
      end
    end
  end

  // Controller history: cleared by reset and whenever the line is lost.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
    end else if (state == ST_SUM) begin
      if (present) begin
        integral <= int_sat;
        prev_err <= err;
      end else begin
        integral <= '0;
        prev_err <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          for (int i = 0; i < pldd_pkg::SENSOR_COUNT; i++) begin
            samp[i] <= in_data[i * pldd_pkg::SAMPLE_W +: pldd_pkg::SAMPLE_W];
          end
          all_below <= 1'b1;
          all_above <= 1'b1;
        end
      end
      ST_SCALE: begin
        if (cnt != '0) begin
          scaled[cnt - pldd_pkg::CNT_W'(1)] <= scaled_now;
          all_below <= all_below && (scaled_now < cfg.border_level);
          all_above <= all_above && (scaled_now > cfg.border_level);
        end
      end
      ST_ERR_DIV: neg <= n_sum[15];
      ST_P_MUL: begin
        err <= err_now;
        neg <= err_now[pldd_pkg::ERR_W-1];
      end
      ST_D_MUL: begin
        term_p <= neg ? -signed'({1'b0, q_p}) : signed'({1'b0, q_p});
        neg    <= diff[8];
      end
      ST_I_MUL: begin
        term_d <= neg ? -signed'({1'b0, q_d}) : signed'({1'b0, q_d});
        neg    <= integral[pldd_pkg::INTEGRAL_W-1];
      end
      ST_I_DIV: i_sat <= |mul_p[pldd_pkg::PROD_W-1:pldd_pkg::MUL_A_W];
      ST_SUM: begin
        res.drive_left   <= clamp_drive(left_full);
        res.drive_right  <= clamp_drive(right_full);
        res.line_present <= present;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/pldd_checker.sv]
// Port-level checks of the line-follow PID drive and their binding to the top level.
module pldd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A result waiting on a stalled consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed or vanished while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again straight after an accept");

  // Both drive commands stay within the clamp limits.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[7:0]) >= -8'sd100) && ($signed(m_axis_tdata[7:0]) <= 8'sd100) &&
      ($signed(m_axis_tdata[15:8]) >= -8'sd100) && ($signed(m_axis_tdata[15:8]) <= 8'sd100))
    else $error("drive command outside clamp limits");

  // Reset leaves no result pending and the input side open.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind pid_line_follow_drive pldd_checker u_pldd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
